[rtl/core/scfp_pkg.sv]
// Shared types, character codes and sizes for the serial command frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package scfp_pkg;

	// Frame characters
	localparam logic [7:0] CH_LT = 8'h3C;  // '<'
	localparam logic [7:0] CH_GT = 8'h3E;  // '>'
	localparam logic [7:0] CH_F  = 8'h46;  // 'F'
	localparam logic [7:0] CH_R  = 8'h52;  // 'R'
	localparam logic [7:0] CH_1  = 8'h31;  // '1'
	localparam logic [7:0] CH_H  = 8'h48;  // 'H'
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam int CMD_SIZE_DEF   = 16;
	localparam int FRAME_OVERHEAD = 4;
	localparam int CNT_W          = 5;
	localparam int BYTE_W         = 8;
	localparam int QUEUE_DEPTH    = 4;

	// Result event codes
	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_EMPTY    = 2'd1,
		EV_ERR_CMD  = 2'd2,
		EV_ERR_LONG = 2'd3
	} event_t;

	// Operations handed from the parser to the executor
	typedef enum logic [1:0] {
		OP_STORE    = 2'd0,
		OP_DONE     = 2'd1,
		OP_ERR_CMD  = 2'd2,
		OP_ERR_LONG = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [BYTE_W-1:0]  data;   // payload byte for OP_STORE
		logic [CNT_W-1:0]   cnt;    // store index or command length
		logic               dev_type;
		logic               dev_unit;
	} q_entry_t;

endpackage
`default_nettype wire

[rtl/core/scfp_front.sv]
// Frame parser front end: accepts received bytes, tracks the frame phase and
// turns payload bytes, frame ends and errors into queued operations. Depends on scfp_pkg.
`default_nettype none
module scfp_front #(
	parameter int CMD_SIZE = scfp_pkg::CMD_SIZE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [scfp_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                       q_full,
	output logic                            in_stall,
	output logic                            q_push,
	output scfp_pkg::q_entry_t              q_entry
);
	import scfp_pkg::*;

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(CMD_SIZE + FRAME_OVERHEAD);

	typedef enum logic [3:0] {
		P_HUNT = 4'b0001,
		P_TYPE = 4'b0010,
		P_UNIT = 4'b0100,
		P_DATA = 4'b1000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             type_q, type_d;
	logic             unit_q, unit_d;
	logic             take;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full && rx_byte != CH_LF && rx_byte != CH_CR;

	always_comb begin
		phase_d          = phase_q;
		cnt_d            = cnt_q;
		type_d           = type_q;
		unit_d           = unit_q;
		q_push           = 1'b0;
		q_entry.op       = OP_STORE;
		q_entry.data     = rx_byte;
		q_entry.cnt      = cnt_q;
		q_entry.dev_type = type_q;
		q_entry.dev_unit = unit_q;
		if (take) begin
			unique case (phase_q)
				P_HUNT: begin
					if (rx_byte == CH_LT)
						phase_d = P_TYPE;
				end
				P_TYPE: begin
					if (rx_byte == CH_F || rx_byte == CH_R) begin
						type_d  = (rx_byte == CH_R);
						phase_d = P_UNIT;
					end else begin
						q_push     = 1'b1;
						q_entry.op = OP_ERR_CMD;
						phase_d    = P_HUNT;
					end
				end
				P_UNIT: begin
					if (rx_byte == CH_1 || rx_byte == CH_H) begin
						unit_d  = (rx_byte == CH_H);
						cnt_d   = '0;
						phase_d = P_DATA;
					end else begin
						q_push     = 1'b1;
						q_entry.op = OP_ERR_CMD;
						phase_d    = P_HUNT;
					end
				end
				P_DATA: begin
					if (cnt_q > LIMIT) begin
						q_push     = 1'b1;
						q_entry.op = OP_ERR_LONG;
						phase_d    = P_HUNT;
					end else if (rx_byte == CH_GT) begin
						q_push     = 1'b1;
						q_entry.op = OP_DONE;
						phase_d    = P_HUNT;
					end else if (rx_byte == CH_LT) begin
						// restart at the type byte, count kept until a new unit byte
						phase_d = P_TYPE;
					end else begin
						// the byte at the limit is counted but never read back
						q_push = (cnt_q < LIMIT);
						cnt_d  = cnt_q + CNT_W'(1);
					end
				end
				default: phase_d = P_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_HUNT;
			cnt_q   <= '0;
			type_q  <= 1'b0;
			unit_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			type_q  <= type_d;
			unit_q  <= unit_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/scfp_queue.sv]
// Short operation queue between the parser front end and the executor.
// Depends on scfp_pkg for the entry type.
`default_nettype none
module scfp_queue #(
	parameter int DEPTH = scfp_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire scfp_pkg::q_entry_t push_entry,
	input  wire logic               pop,
	output scfp_pkg::q_entry_t      head,
	output logic                    full,
	output logic                    empty
);
	import scfp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            do_push, do_pop;

	assign full    = (fill_q == CW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				fill_q <= fill_q + CW'(1);
			else if (do_pop && !do_push)
				fill_q <= fill_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

[rtl/core/scfp_back.sv]
// Executor: holds the payload memory, performs queued operations and drives
// the registered result port. Depends on scfp_pkg.
`default_nettype none
module scfp_back #(
	parameter int CMD_SIZE = scfp_pkg::CMD_SIZE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire scfp_pkg::q_entry_t          q_head,
	input  wire logic                        q_empty,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       event_res,
	output logic [scfp_pkg::BYTE_W-1:0]      payload_byte,
	output logic [scfp_pkg::CNT_W-1:0]       payload_index,
	output logic [scfp_pkg::CNT_W-1:0]       payload_length,
	output logic                             device_type,
	output logic                             device_unit,
	output logic                             last
);
	import scfp_pkg::*;

	localparam int LIMIT  = CMD_SIZE + FRAME_OVERHEAD;
	localparam int MEM_AW = $clog2(LIMIT);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_EMIT = 2'b10
	} back_state_t;

	back_state_t         state_q;
	logic [BYTE_W-1:0]   mem [LIMIT];
	logic [BYTE_W-1:0]   rd_data_q;
	logic [MEM_AW-1:0]   idx_q;
	logic [CNT_W-1:0]    len_q;
	logic                typ_q, unit_q;
	logic                out_valid_q;
	logic [1:0]          event_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [CNT_W-1:0]    index_q, length_q;
	logic                dtype_q, dunit_q, last_q;

	logic                out_free, wr_en, rd_en, emit_last;
	logic [MEM_AW-1:0]   rd_addr;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == B_IDLE) && !q_empty
	                   && (q_head.op == OP_STORE || out_free);
	assign wr_en     = q_pop && q_head.op == OP_STORE;
	assign emit_last = (CNT_W'(idx_q) + CNT_W'(1) == len_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (q_pop && q_head.op == OP_DONE && q_head.cnt != '0)
			rd_en = 1'b1;
		else if (state_q == B_EMIT && out_free && !emit_last) begin
			rd_en   = 1'b1;
			rd_addr = idx_q + MEM_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[q_head.cnt[MEM_AW-1:0]] <= q_head.data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_pop && q_head.op != OP_STORE) begin
						out_valid_q <= !(q_head.op == OP_DONE && q_head.cnt != '0);
						if (q_head.op == OP_DONE && q_head.cnt != '0)
							state_q <= B_EMIT;
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (emit_last)
							state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// result and walk registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_pop && q_head.op != OP_STORE) begin
			byte_q   <= '0;
			index_q  <= '0;
			length_q <= '0;
			last_q   <= 1'b1;
			typ_q    <= q_head.dev_type;
			unit_q   <= q_head.dev_unit;
			len_q    <= q_head.cnt;
			idx_q    <= '0;
			unique case (q_head.op)
				OP_DONE: begin
					event_q <= EV_EMPTY;
					dtype_q <= q_head.dev_type;
					dunit_q <= q_head.dev_unit;
				end
				OP_ERR_CMD: begin
					event_q <= EV_ERR_CMD;
					dtype_q <= 1'b0;
					dunit_q <= 1'b0;
				end
				default: begin
					event_q <= EV_ERR_LONG;
					dtype_q <= 1'b0;
					dunit_q <= 1'b0;
				end
			endcase
		end else if (state_q == B_EMIT && out_free) begin
			event_q  <= EV_PAYLOAD;
			byte_q   <= rd_data_q;
			index_q  <= CNT_W'(idx_q);
			length_q <= len_q;
			dtype_q  <= typ_q;
			dunit_q  <= unit_q;
			last_q   <= emit_last;
			idx_q    <= idx_q + MEM_AW'(1);
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = event_q;
	assign payload_byte   = byte_q;
	assign payload_index  = index_q;
	assign payload_length = length_q;
	assign device_type    = dtype_q;
	assign device_unit    = dunit_q;
	assign last           = last_q;

endmodule
`default_nettype wire

[rtl/core/serial_command_frame_parser.sv]
// Serial command frame parser. A received byte is taken whenever the four-entry
// operation queue has room (in_stall is high only while it is full); CR and LF are
// dropped. Frames read '<', type 'F' or 'R', unit '1' or 'H', payload, '>'. The
// executor behind the queue writes each payload byte to its memory, and on '>' makes
// the first memory read and then gives one result per cycle while out_stall is low,
// taking no new operation until the last payload result; errors and empty commands
// give a single result. Depends on scfp_pkg, scfp_front, scfp_queue and scfp_back.
`default_nettype none
module serial_command_frame_parser #(
	parameter int CMD_SIZE = scfp_pkg::CMD_SIZE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [scfp_pkg::BYTE_W-1:0] rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       event_res,
	output logic [scfp_pkg::BYTE_W-1:0]      payload_byte,
	output logic [scfp_pkg::CNT_W-1:0]       payload_index,
	output logic [scfp_pkg::CNT_W-1:0]       payload_length,
	output logic                             device_type,
	output logic                             device_unit,
	output logic                             last
);
	import scfp_pkg::*;

	q_entry_t push_entry, head;
	logic     push, pop, full, empty;

	scfp_front #(.CMD_SIZE(CMD_SIZE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.in_stall (in_stall),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	scfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	scfp_back #(.CMD_SIZE(CMD_SIZE)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_head         (head),
		.q_empty        (empty),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.payload_length (payload_length),
		.device_type    (device_type),
		.device_unit    (device_unit),
		.last           (last)
	);

endmodule
`default_nettype wire

[rtl/core/scfp_checker.sv]
// Port-level checks of the result stream of the frame parser, bound to the top
// level. Depends on scfp_pkg.
`default_nettype none
module scfp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [1:0]                  event_res,
	input wire logic [scfp_pkg::BYTE_W-1:0] payload_byte,
	input wire logic [scfp_pkg::CNT_W-1:0]  payload_index,
	input wire logic [scfp_pkg::CNT_W-1:0]  payload_length,
	input wire logic                        last
);
	import scfp_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res)
		&& $stable(payload_byte) && $stable(payload_index) && $stable(last))
		else $error("stalled result changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> last && payload_byte == '0
		&& payload_index == '0)
		else $error("non-payload event not a single clean result");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_PAYLOAD |-> payload_index < payload_length
		&& last == (payload_index + CNT_W'(1) == payload_length))
		else $error("payload index or last mark inconsistent with length");

	// advance through the payload without gaps
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_res == EV_PAYLOAD && !last
		|=> out_valid && event_res == EV_PAYLOAD
		&& payload_index == $past(payload_index) + CNT_W'(1))
		else $error("payload burst broken");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.event_res      (event_res),
	.payload_byte   (payload_byte),
	.payload_index  (payload_index),
	.payload_length (payload_length),
	.last           (last)
);
`default_nettype wire

[tb/frame_result_checker.sv]
`timescale 1ns / 100ps
// Watches both channels of serial_command_frame_parser, predicts the results of
// every accepted byte and compares each accepted result against them. Uses scfp_pkg.
module frame_result_checker #(
	parameter int CMD_SIZE = scfp_pkg::CMD_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] event_res,
	input  logic [7:0] payload_byte,
	input  logic [4:0] payload_index,
	input  logic [4:0] payload_length,
	input  logic       device_type,
	input  logic       device_unit,
	input  logic       last,
	output int         fail_count,
	output int         pending
);
	import scfp_pkg::*;

	localparam int STORE_LEN = CMD_SIZE + FRAME_OVERHEAD;

	typedef enum logic [1:0] {
		HUNT_START,
		GET_TYPE,
		GET_UNIT,
		COLLECT
	} parse_state_t;

	typedef struct {
		event_t     ev;
		logic [7:0] data;
		logic [4:0] idx;
		logic [4:0] len;
		logic       dtype;
		logic       dunit;
		logic       lst;
	} frame_result_t;

	frame_result_t due_results[$];
	parse_state_t  state;
	logic [7:0]    body_bytes[STORE_LEN];
	logic [4:0]    body_count;
	logic          type_seen;
	logic          unit_seen;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic add_result(input event_t ev, input logic [7:0] data,
			input logic [4:0] idx, input logic [4:0] len, input logic dtype,
			input logic dunit, input logic lst);
		frame_result_t r;
		r.ev    = ev;
		r.data  = data;
		r.idx   = idx;
		r.len   = len;
		r.dtype = dtype;
		r.dunit = dunit;
		r.lst   = lst;
		due_results.push_back(r);
	endtask

	// Advance the parse state by one received byte and queue what it causes.
	task automatic parse_rx_byte(input logic [7:0] c);
		if (c != CH_LF && c != CH_CR) begin
			case (state)
				HUNT_START: begin
					if (c == CH_LT)
						state = GET_TYPE;
				end
				GET_TYPE: begin
					if (c == CH_F || c == CH_R) begin
						type_seen = (c == CH_R);
						state     = GET_UNIT;
					end else begin
						state = HUNT_START;
						add_result(EV_ERR_CMD, 8'h00, 5'd0, 5'd0, 1'b0, 1'b0, 1'b1);
					end
				end
				GET_UNIT: begin
					if (c == CH_1 || c == CH_H) begin
						unit_seen  = (c == CH_H);
						body_count = 5'd0;
						state      = COLLECT;
					end else begin
						state = HUNT_START;
						add_result(EV_ERR_CMD, 8'h00, 5'd0, 5'd0, 1'b0, 1'b0, 1'b1);
					end
				end
				default: begin
					if (body_count > STORE_LEN) begin
						// any byte past the overlong point is swallowed as an error
						state = HUNT_START;
						add_result(EV_ERR_LONG, 8'h00, 5'd0, 5'd0, 1'b0, 1'b0, 1'b1);
					end else if (c == CH_GT) begin
						state = HUNT_START;
						if (body_count == 5'd0)
							add_result(EV_EMPTY, 8'h00, 5'd0, 5'd0, type_seen, unit_seen, 1'b1);
						else
							for (int i = 0; i < body_count; i++)
								add_result(EV_PAYLOAD, body_bytes[i], i[4:0], body_count,
									type_seen, unit_seen, (i + 1 == body_count));
					end else if (c == CH_LT) begin
						// restart at the type byte, keep the count until a new unit
						state = GET_TYPE;
					end else begin
						if (body_count < STORE_LEN)
							body_bytes[body_count] = c;
						body_count = body_count + 5'd1;
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t r;
		if (!arst_n) begin
			state      = HUNT_START;
			body_count = 5'd0;
			type_seen  = 1'b0;
			unit_seen  = 1'b0;
			for (int i = 0; i < STORE_LEN; i++)
				body_bytes[i] = 8'h00;
		end else begin
			if (in_valid && !in_stall)
				parse_rx_byte(rx_byte);
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing due, event_res", {6'd0, event_res},
						8'h00);
				end else begin
					r = due_results.pop_front();
					if (event_res !== r.ev)
						report_mismatch("event_res", {6'd0, event_res}, {6'd0, r.ev});
					if (payload_byte !== r.data)
						report_mismatch("payload_byte", payload_byte, r.data);
					if (payload_index !== r.idx)
						report_mismatch("payload_index", {3'd0, payload_index}, {3'd0, r.idx});
					if (payload_length !== r.len)
						report_mismatch("payload_length", {3'd0, payload_length}, {3'd0, r.len});
					if (device_type !== r.dtype)
						report_mismatch("device_type", {7'd0, device_type}, {7'd0, r.dtype});
					if (device_unit !== r.dunit)
						report_mismatch("device_unit", {7'd0, device_unit}, {7'd0, r.dunit});
					if (last !== r.lst)
						report_mismatch("last", {7'd0, last}, {7'd0, r.lst});
				end
			end
			pending = due_results.size();
		end
	end

endmodule

[tb/serial_command_frame_parser_tb.sv]
`timescale 1ns / 100ps
// Top of the serial_command_frame_parser testbench: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on scfp_pkg and frame_result_checker.
module serial_command_frame_parser_tb;
	import scfp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;
	localparam int ITEM_TARGET = 170;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] event_res;
	logic [7:0] payload_byte;
	logic [4:0] payload_index;
	logic [4:0] payload_length;
	logic       device_type;
	logic       device_unit;
	logic       last;

	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   sent_items = 0;
	bit   gaps_on = 1'b1;
	bit   paused = 1'b0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;

	serial_command_frame_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.payload_length (payload_length),
		.device_type    (device_type),
		.device_unit    (device_unit),
		.last           (last)
	);

	frame_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.payload_length (payload_length),
		.device_type    (device_type),
		.device_unit    (device_unit),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: one long hold on request, otherwise random stall bursts.
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one byte and hold it until the transfer, then maybe idle a while.
	task automatic send_byte(input logic [7:0] b);
		rx_byte  <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items++;
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_LT || b == CH_GT || b == CH_LF || b == CH_CR);
		return b;
	endfunction

	// Random byte that is neither of the two accepted codes nor CR or LF.
	function automatic logic [7:0] wrong_byte(input logic [7:0] ok_a, input logic [7:0] ok_b);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ok_a || b == ok_b || b == CH_LF || b == CH_CR);
		return b;
	endfunction

	task automatic send_header();
		send_byte($urandom_range(0, 1) ? CH_R : CH_F);
		send_byte($urandom_range(0, 1) ? CH_H : CH_1);
	endtask

	task automatic send_body(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
			send_byte(body_byte());
		end
	endtask

	task automatic send_command(input int n);
		send_byte(CH_LT);
		send_header();
		send_body(n);
		send_byte(CH_GT);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 5);
		else if (r < 85)
			return $urandom_range(6, 19);
		else if (r < 93)
			return 20;
		else
			return $urandom_range(21, 23);
	endfunction

	initial begin
		int kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// stray bytes while hunting, then an empty command
		send_byte(8'h00);
		send_byte(CH_GT);
		send_byte(CH_LT);
		send_byte(CH_F);
		send_byte(CH_1);
		send_byte(CH_GT);
		// bad type, then a start byte where the unit belongs
		send_byte(CH_LT);
		send_byte(8'hFF);
		send_byte(CH_LT);
		send_byte(CH_R);
		send_byte(CH_LT);
		// CR and LF inside the header, restart while collecting
		send_byte(CH_LT);
		send_byte(CH_CR);
		send_byte(CH_R);
		send_byte(CH_LF);
		send_byte(CH_H);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_LT);
		send_byte(CH_F);
		send_byte(CH_1);
		send_byte(8'h5A);
		send_byte(CH_GT);

		while (sent_items < ITEM_TARGET) begin
			if (!calm && sent_items >= ITEM_TARGET - 40)
				calm <= 1'b1;
			if (!hold_req && sent_items >= 60) begin
				// keep offering bytes while the receiver holds off
				hold_req <= 1'b1;
				gaps_on = 1'b0;
				send_command(20);
				send_command(22);
				send_command(3);
				gaps_on = 1'b1;
			end else if (!paused && sent_items >= 120) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end else begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					send_command(pick_length());
				end else if (kind < 68) begin
					send_byte(CH_LT);
					send_byte(wrong_byte(CH_F, CH_R));
				end else if (kind < 76) begin
					send_byte(CH_LT);
					send_byte($urandom_range(0, 1) ? CH_R : CH_F);
					send_byte(wrong_byte(CH_1, CH_H));
				end else if (kind < 88) begin
					send_byte(CH_LT);
					send_header();
					send_body($urandom_range(0, 6));
					send_command(pick_length());
				end else begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/core/scfp_pkg.sv
rtl/core/scfp_front.sv
rtl/core/scfp_queue.sv
rtl/core/scfp_back.sv
rtl/core/serial_command_frame_parser.sv
rtl/core/scfp_checker.sv
tb/frame_result_checker.sv
tb/serial_command_frame_parser_tb.sv
